// ===== sv/hesd_pkg.sv =====
// Shared types and constants of the HTML entity stream decoder.
// No dependencies; every module of the decoder imports this package.
package hesd_pkg;

	// Look-ahead window after '&'. Names are at most five characters long.
	localparam int LOOKAHEAD_DEPTH = 5;
	localparam int NAME_MAX_LEN    = 5;
	localparam int NAME_COUNT      = 15;

	// Bytes actually held: never more than a name prefix that is not yet a whole name.
	localparam int HELD_DEPTH = (LOOKAHEAD_DEPTH - 1 < NAME_MAX_LEN - 1) ?
		(LOOKAHEAD_DEPTH - 1) : (NAME_MAX_LEN - 1);
	localparam int HELD_IDX_W = $clog2(HELD_DEPTH);
	localparam int CNT_W      = $clog2(NAME_MAX_LEN + 1);

	// Worst case per input byte: '&', the held prefix, and one more byte.
	localparam int MAX_OUT   = HELD_DEPTH + 2;
	localparam int OUT_IDX_W = $clog2(MAX_OUT);
	localparam int OUT_CNT_W = $clog2(MAX_OUT + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} hesd_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} hesd_out_t;

	// One command from the front: the bytes that one input beat produces.
	typedef struct packed {
		logic [MAX_OUT-1:0][7:0] data;
		logic [OUT_CNT_W-1:0]    cnt;
		logic                    last;
	} hesd_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} hesd_qstat_t;

endpackage

// ===== sv/hesd_front.sv =====
// Front end of the decoder: accepts input beats, runs the entity parser and
// turns each beat into one command of output bytes. Depends on hesd_pkg.
module hesd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  hesd_pkg::hesd_in_t  item,
	input  logic                push,
	input  logic                full,
	output logic                cmd_push,
	output hesd_pkg::hesd_cmd_t cmd
);
	import hesd_pkg::*;

	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_X    = 8'h78;
	localparam int NAME_IDX_W = $clog2(NAME_COUNT);

	typedef enum logic [2:0] {
		PH_PLAIN,
		PH_ENTITY,
		PH_DROP,
		PH_HASH,
		PH_DIGITS
	} phase_t;

	typedef struct packed {
		logic [CNT_W-1:0]              len;
		logic [0:NAME_MAX_LEN-1][7:0]  name;
		logic [1:0]                    rlen;
		logic [0:2][7:0]               rep;
	} ent_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} digit_t;

	function automatic ent_t ent_entry(input logic [NAME_IDX_W-1:0] idx);
		ent_t e;
		case (idx)
			4'd0:    e = '{len: 3'd4, name: {"nbsp", 8'h00},  rlen: 2'd1, rep: {8'h20, 16'h0}};
			4'd1:    e = '{len: 3'd2, name: {"lt", 24'h0},    rlen: 2'd1, rep: {8'h3C, 16'h0}};
			4'd2:    e = '{len: 3'd2, name: {"gt", 24'h0},    rlen: 2'd1, rep: {8'h3E, 16'h0}};
			4'd3:    e = '{len: 3'd3, name: {"amp", 16'h0},   rlen: 2'd1, rep: {8'h26, 16'h0}};
			4'd4:    e = '{len: 3'd4, name: {"cent", 8'h00},  rlen: 2'd2, rep: {16'hC2A2, 8'h0}};
			4'd5:    e = '{len: 3'd5, name: "pound",          rlen: 2'd2, rep: {16'hC2A3, 8'h0}};
			4'd6:    e = '{len: 3'd3, name: {"yen", 16'h0},   rlen: 2'd2, rep: {16'hC2A5, 8'h0}};
			4'd7:    e = '{len: 3'd4, name: {"euro", 8'h00},  rlen: 2'd3, rep: 24'hE282AC};
			4'd8:    e = '{len: 3'd4, name: {"sect", 8'h00},  rlen: 2'd2, rep: {16'hC2A7, 8'h0}};
			4'd9:    e = '{len: 3'd4, name: {"copy", 8'h00},  rlen: 2'd2, rep: {16'hC2A9, 8'h0}};
			4'd10:   e = '{len: 3'd3, name: {"reg", 16'h0},   rlen: 2'd2, rep: {16'hC2AE, 8'h0}};
			4'd11:   e = '{len: 3'd5, name: "trade",          rlen: 2'd3, rep: 24'hE284A2};
			4'd12:   e = '{len: 3'd4, name: {"apos", 8'h00},  rlen: 2'd1, rep: {8'h27, 16'h0}};
			4'd13:   e = '{len: 3'd5, name: "ndash",          rlen: 2'd1, rep: {8'h2D, 16'h0}};
			4'd14:   e = '{len: 3'd4, name: {"quot", 8'h00},  rlen: 2'd1, rep: {8'h22, 16'h0}};
			default: e = '0;
		endcase
		return e;
	endfunction

	function automatic digit_t digit_of(input logic [7:0] b, input logic hex);
		digit_t d;
		d = '0;
		if (b inside {[8'h30:8'h39]}) begin
			d.ok  = 1'b1;
			d.val = 4'(b - 8'h30);
		end else if (hex && (b inside {[8'h61:8'h66]})) begin
			d.ok  = 1'b1;
			d.val = 4'(b - 8'h57);
		end else if (hex && (b inside {[8'h41:8'h46]})) begin
			d.ok  = 1'b1;
			d.val = 4'(b - 8'h37);
		end
		return d;
	endfunction

	phase_t                phase_q, phase_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic [NAME_COUNT-1:0] mask_q, mask_d;
	logic [7:0]            num_q, num_d;
	logic                  hex_q, hex_d;
	logic [7:0]            held_q [HELD_DEPTH];
	logic [7:0]            held_d [HELD_DEPTH];

	logic                  accept;
	logic [7:0]            b;
	logic [NAME_COUNT-1:0] hit;
	logic                  full_hit, pre_hit, do_digit;
	logic [NAME_IDX_W-1:0] sel;
	ent_t                  ent_v;
	digit_t                dig;
	logic [OUT_IDX_W-1:0]  k;
	logic [MAX_OUT-1:0][7:0] data;

	assign accept = push && !full;
	assign b      = item.in_byte;

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		mask_d   = mask_q;
		num_d    = num_q;
		hex_d    = hex_q;
		held_d   = held_q;
		data     = '0;
		k        = '0;
		hit      = '0;
		full_hit = 1'b0;
		pre_hit  = 1'b0;
		do_digit = 1'b0;
		sel      = '0;
		ent_v    = '0;
		dig      = '0;

		case (phase_q)
			PH_ENTITY: begin
				if (cnt_q == '0 && b == CH_HASH) begin
					phase_d = PH_HASH;
					num_d   = '0;
					hex_d   = 1'b0;
				end else begin
					if (32'(cnt_q) < NAME_MAX_LEN && 32'(cnt_q) < LOOKAHEAD_DEPTH) begin
						// Every surviving name is tested at the current position.
						for (int i = 0; i < NAME_COUNT; i++) begin
							ent_v  = ent_entry(NAME_IDX_W'(i));
							hit[i] = mask_q[i] && (ent_v.len > cnt_q) &&
								(ent_v.name[cnt_q] == b);
							if (hit[i] && ent_v.len == CNT_W'(cnt_q + 1'b1))
								full_hit = 1'b1;
							if (hit[i] && ent_v.len > CNT_W'(cnt_q + 1'b1))
								pre_hit = 1'b1;
						end
						for (int i = NAME_COUNT - 1; i >= 0; i--) begin
							ent_v = ent_entry(NAME_IDX_W'(i));
							if (hit[i] && ent_v.len == CNT_W'(cnt_q + 1'b1))
								sel = NAME_IDX_W'(i);
						end
					end
					if (full_hit) begin
						ent_v = ent_entry(sel);
						for (int r = 0; r < 3; r++) begin
							if (r < ent_v.rlen) begin
								data[k] = ent_v.rep[r];
								k       = k + 1'b1;
							end
						end
						cnt_d   = '0;
						phase_d = PH_DROP;
					end else if (pre_hit && 32'(cnt_q) + 1 < LOOKAHEAD_DEPTH) begin
						held_d[cnt_q[HELD_IDX_W-1:0]] = b;
						cnt_d  = CNT_W'(cnt_q + 1'b1);
						mask_d = hit;
					end else begin
						// No name can continue: replay '&' and the prefix, then
						// treat the breaking byte as plain text.
						data[k] = CH_AMP;
						k       = k + 1'b1;
						for (int i = 0; i < HELD_DEPTH; i++) begin
							if (i < cnt_q) begin
								data[k] = held_q[i];
								k       = k + 1'b1;
							end
						end
						cnt_d   = '0;
						phase_d = PH_PLAIN;
						if (b == CH_AMP) begin
							phase_d = PH_ENTITY;
							mask_d  = '1;
						end else begin
							data[k] = b;
							k       = k + 1'b1;
						end
					end
				end
			end
			PH_DROP: begin
				phase_d = PH_PLAIN;
			end
			PH_HASH: begin
				num_d   = '0;
				phase_d = PH_DIGITS;
				if (b == CH_X) begin
					hex_d = 1'b1;
				end else begin
					hex_d    = 1'b0;
					do_digit = 1'b1;
				end
			end
			PH_DIGITS: begin
				do_digit = 1'b1;
			end
			default: begin
				phase_d = PH_PLAIN;
				if (b == CH_AMP) begin
					phase_d = PH_ENTITY;
					cnt_d   = '0;
					mask_d  = '1;
				end else begin
					data[k] = b;
					k       = k + 1'b1;
				end
			end
		endcase

		if (do_digit) begin
			dig = digit_of(b, hex_d);
			if (dig.ok) begin
				if (hex_d)
					num_d = {num_d[3:0], dig.val};
				else
					num_d = {num_d[4:0], 3'b000} + {num_d[6:0], 1'b0} + {4'b0000, dig.val};
			end else begin
				if (num_d != '0) begin
					data[k] = num_d;
					k       = k + 1'b1;
				end
				num_d   = '0;
				hex_d   = 1'b0;
				phase_d = PH_PLAIN;
			end
		end

		// End of text: whatever is still pending flushes, then all state clears.
		if (item.in_last) begin
			if (phase_d == PH_ENTITY) begin
				data[k] = CH_AMP;
				k       = k + 1'b1;
				for (int i = 0; i < HELD_DEPTH; i++) begin
					if (i < cnt_d) begin
						data[k] = held_d[i];
						k       = k + 1'b1;
					end
				end
			end else if (phase_d == PH_DIGITS && num_d != '0) begin
				data[k] = num_d;
				k       = k + 1'b1;
			end
			phase_d = PH_PLAIN;
			cnt_d   = '0;
			num_d   = '0;
			hex_d   = 1'b0;
			mask_d  = '1;
		end
	end

	assign cmd_push = accept && (k != '0);
	assign cmd.data = data;
	assign cmd.cnt  = OUT_CNT_W'(k);
	assign cmd.last = item.in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PLAIN;
			cnt_q   <= '0;
			mask_q  <= '1;
			num_q   <= '0;
			hex_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			mask_q  <= mask_d;
			num_q   <= num_d;
			hex_q   <= hex_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= held_d;
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.in_last |=> phase_q == PH_PLAIN && cnt_q == '0 && num_q == '0)
		else $error("state not cleared after the final beat");

	a_cnt_only_in_entity: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_ENTITY |-> cnt_q == '0)
		else $error("held bytes outside an entity name");

endmodule

// ===== sv/hesd_cmd_queue.sv =====
// Short command queue between the parser front and the byte back end.
// Depends on hesd_pkg for the command type and the queue depth.
module hesd_cmd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  hesd_pkg::hesd_cmd_t   wr_cmd,
	input  logic                  rd_en,
	output hesd_pkg::hesd_cmd_t   head,
	output hesd_pkg::hesd_qstat_t status
);
	import hesd_pkg::*;

	hesd_cmd_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
	endfunction

	assign status.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (rd_en)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + 1'b1;
			else if (rd_en && !wr_en)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !status.full)
		else $error("command written into a full queue");

endmodule

// ===== sv/hesd_back.sv =====
// Back end of the decoder: walks the head command one byte per beat and
// releases the command after its last byte. Depends on hesd_pkg.
module hesd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hesd_pkg::hesd_cmd_t   head,
	input  hesd_pkg::hesd_qstat_t status,
	input  logic                  pop,
	output hesd_pkg::hesd_out_t   result,
	output logic                  deq
);
	import hesd_pkg::*;

	logic [OUT_IDX_W-1:0] idx_q;
	logic                 take, at_end;

	assign take   = pop && !status.empty;
	assign at_end = (OUT_CNT_W'(idx_q) + 1'b1) == head.cnt;
	assign deq    = take && at_end;

	assign result.out_byte = head.data[idx_q];
	assign result.out_last = head.last && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (deq) begin
			idx_q <= '0;
		end else if (take) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	a_idx_in_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!status.empty |-> OUT_CNT_W'(idx_q) < head.cnt)
		else $error("byte index beyond the head command");

endmodule

// ===== sv/html_entity_stream_decoder_top.sv =====
// Top level of the HTML entity stream decoder: parser front, command queue
// and byte back end. Depends on hesd_pkg, hesd_front, hesd_cmd_queue, hesd_back.
//
//   channel | handshake            | payload
//   input   | push / full          | item   (in_byte, in_last)
//   result  | empty / pop          | result (out_byte, out_last)
//
// An input beat is parsed in the cycle it is accepted, so one beat per cycle
// goes in while the two-entry command queue has room; full is the queue full.
// Each beat yields zero to six bytes, and the back end delivers one byte per
// cycle while pop is high and the queue is not empty.
// Reset clears the parser phase, the queue and the back end's byte index.
// A stalled result side fills the queue and then holds the input side off.
module html_entity_stream_decoder_top (
	input  logic               clk,
	input  logic               arst_n,
	input  hesd_pkg::hesd_in_t item,
	input  logic               push,
	output logic               full,
	output hesd_pkg::hesd_out_t result,
	output logic               empty,
	input  logic               pop
);
	import hesd_pkg::*;

	hesd_cmd_t   cmd, head;
	logic        cmd_push, deq;
	hesd_qstat_t q_status;

	assign full  = q_status.full;
	assign empty = q_status.empty;

	hesd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.push     (push),
		.full     (q_status.full),
		.cmd_push (cmd_push),
		.cmd      (cmd)
	);

	hesd_cmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_cmd (cmd),
		.rd_en  (deq),
		.head   (head),
		.status (q_status)
	);

	hesd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.status (q_status),
		.pop    (pop),
		.result (result),
		.deq    (deq)
	);

endmodule

// ===== bench/html_entity_stream_decoder_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the HTML entity stream decoder: predicts the decoded bytes of every
// accepted input beat and compares them with the result beats. Depends on hesd_pkg.
module html_entity_stream_decoder_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  hesd_pkg::hesd_in_t  item,
	input  logic                push,
	input  logic                full,
	input  hesd_pkg::hesd_out_t result,
	input  logic                empty,
	input  logic                pop,
	output int                  fail_count,
	output int                  outstanding,
	output int                  bytes_checked
);

	typedef enum logic [2:0] {
		PH_TEXT,
		PH_NAME,
		PH_SKIP,
		PH_HASH,
		PH_NUMBER
	} parse_phase_t;

	// Name characters and replacement bytes are left-justified.
	typedef struct packed {
		logic [2:0]  len;
		logic [39:0] chars;
		logic [1:0]  rlen;
		logic [23:0] rep;
	} entity_t;

	parse_phase_t        phase;
	logic [7:0]          held [hesd_pkg::LOOKAHEAD_DEPTH];
	int                  held_n;
	logic [7:0]          num_val;
	logic                num_hex;
	logic [7:0]          beat_bytes[$];
	hesd_pkg::hesd_out_t expected_bytes[$];

	function automatic entity_t name_entry(input int idx);
		case (idx)
			0:       name_entry = {3'd4, "nbsp", 8'h00,  2'd1, 24'h200000};
			1:       name_entry = {3'd2, "lt", 24'h0,    2'd1, 24'h3C0000};
			2:       name_entry = {3'd2, "gt", 24'h0,    2'd1, 24'h3E0000};
			3:       name_entry = {3'd3, "amp", 16'h0,   2'd1, 24'h260000};
			4:       name_entry = {3'd4, "cent", 8'h00,  2'd2, 24'hC2A200};
			5:       name_entry = {3'd5, "pound",        2'd2, 24'hC2A300};
			6:       name_entry = {3'd3, "yen", 16'h0,   2'd2, 24'hC2A500};
			7:       name_entry = {3'd4, "euro", 8'h00,  2'd3, 24'hE282AC};
			8:       name_entry = {3'd4, "sect", 8'h00,  2'd2, 24'hC2A700};
			9:       name_entry = {3'd4, "copy", 8'h00,  2'd2, 24'hC2A900};
			10:      name_entry = {3'd3, "reg", 16'h0,   2'd2, 24'hC2AE00};
			11:      name_entry = {3'd5, "trade",        2'd3, 24'hE284A2};
			12:      name_entry = {3'd4, "apos", 8'h00,  2'd1, 24'h270000};
			13:      name_entry = {3'd5, "ndash",        2'd1, 24'h2D0000};
			default: name_entry = {3'd4, "quot", 8'h00,  2'd1, 24'h220000};
		endcase
	endfunction

	task automatic put_byte(input logic [7:0] b);
		beat_bytes.insert(beat_bytes.size(), b);
	endtask

	task automatic clear_parser();
		phase = PH_TEXT;
		held_n = 0;
		num_val = '0;
		num_hex = 1'b0;
	endtask

	task automatic take_text_byte(input logic [7:0] b);
		if (b == "&") begin
			phase = PH_NAME;
			held_n = 0;
		end else begin
			put_byte(b);
		end
	endtask

	task automatic flush_name();
		put_byte("&");
		for (int i = 0; i < held_n; i++) put_byte(held[i]);
		held_n = 0;
	endtask

	task automatic take_name_byte(input logic [7:0] b);
		entity_t e;
		int      m;
		bit      prefix;
		bit      same;
		if (held_n == 0 && b == "#") begin
			phase = PH_HASH;
			num_val = '0;
			num_hex = 1'b0;
			return;
		end
		m = held_n + 1;
		prefix = 1'b0;
		// Names never prefix one another, so the first full match is the only one.
		for (int i = 0; i < hesd_pkg::NAME_COUNT; i++) begin
			e = name_entry(i);
			if (e.len < m) continue;
			same = 1'b1;
			for (int k = 0; k < m - 1; k++)
				if (e.chars[39 - 8 * k -: 8] != held[k]) same = 1'b0;
			if (e.chars[39 - 8 * (m - 1) -: 8] != b) same = 1'b0;
			if (!same) continue;
			if (e.len == m) begin
				for (int k = 0; k < e.rlen; k++) put_byte(e.rep[23 - 8 * k -: 8]);
				held_n = 0;
				phase = PH_SKIP;
				return;
			end
			prefix = 1'b1;
		end
		if (prefix && m < hesd_pkg::LOOKAHEAD_DEPTH) begin
			held[held_n] = b;
			held_n = m;
			return;
		end
		// The breaking byte is replayed as text, so it may open a new entity.
		flush_name();
		phase = PH_TEXT;
		take_text_byte(b);
	endtask

	task automatic take_digit(input logic [7:0] b);
		int d;
		d = -1;
		if (b >= "0" && b <= "9") d = b - "0";
		else if (num_hex && b >= "a" && b <= "f") d = b - "a" + 10;
		else if (num_hex && b >= "A" && b <= "F") d = b - "A" + 10;
		if (d >= 0) begin
			num_val = num_hex ? 8'(num_val * 16 + d) : 8'(num_val * 10 + d);
			return;
		end
		if (num_val != 0) put_byte(num_val);
		num_val = '0;
		num_hex = 1'b0;
		phase = PH_TEXT;
	endtask

	task automatic predict_beat(input hesd_pkg::hesd_in_t beat);
		hesd_pkg::hesd_out_t exp_byte;
		beat_bytes.delete();
		case (phase)
			PH_NAME: take_name_byte(beat.in_byte);
			PH_SKIP: phase = PH_TEXT;
			PH_HASH: begin
				num_val = '0;
				phase = PH_NUMBER;
				if (beat.in_byte == "x") begin
					num_hex = 1'b1;
				end else begin
					num_hex = 1'b0;
					take_digit(beat.in_byte);
				end
			end
			PH_NUMBER: take_digit(beat.in_byte);
			default: begin
				phase = PH_TEXT;
				take_text_byte(beat.in_byte);
			end
		endcase
		if (beat.in_last) begin
			if (phase == PH_NAME) flush_name();
			else if (phase == PH_NUMBER && num_val != 0) put_byte(num_val);
			clear_parser();
		end
		for (int i = 0; i < beat_bytes.size(); i++) begin
			exp_byte.out_byte = beat_bytes[i];
			exp_byte.out_last = beat.in_last && (i == beat_bytes.size() - 1);
			expected_bytes.insert(expected_bytes.size(), exp_byte);
		end
	endtask

	task automatic check_result(input hesd_pkg::hesd_out_t got);
		hesd_pkg::hesd_out_t exp_byte;
		bytes_checked++;
		if (expected_bytes.size() == 0) begin
			$error("unexpected result beat: out_byte %h out_last %b",
				got.out_byte, got.out_last);
			fail_count++;
			return;
		end
		exp_byte = expected_bytes.pop_front();
		if (got.out_byte !== exp_byte.out_byte) begin
			$error("out_byte: expected %h, actual %h", exp_byte.out_byte, got.out_byte);
			fail_count++;
		end
		if (got.out_last !== exp_byte.out_last) begin
			$error("out_last: expected %b, actual %b", exp_byte.out_last, got.out_last);
			fail_count++;
		end
	endtask

	// The result is compared before the new beat is predicted: a beat accepted at
	// this edge cannot already be on the result port.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			expected_bytes.delete();
			fail_count = 0;
			bytes_checked = 0;
			outstanding = 0;
		end else begin
			if (pop && !empty) check_result(result);
			if (push && !full) predict_beat(item);
			outstanding = expected_bytes.size();
		end
	end

endmodule

// ===== bench/html_entity_stream_decoder_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the HTML entity stream decoder: clock, reset, text stimulus
// and verdict. Depends on hesd_pkg, the decoder top and html_entity_stream_decoder_checker.
module html_entity_stream_decoder_top_tb;

	logic                clk = 1'b0;
	logic                arst_n;
	hesd_pkg::hesd_in_t  item;
	logic                push;
	logic                full;
	hesd_pkg::hesd_out_t result;
	logic                empty;
	logic                pop;

	int         fail_count;
	int         outstanding;
	int         bytes_checked;
	int         beats_sent;
	int         texts_sent;
	logic       calm;
	logic [7:0] text_q[$];

	html_entity_stream_decoder_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.push   (push),
		.full   (full),
		.result (result),
		.empty  (empty),
		.pop    (pop)
	);

	html_entity_stream_decoder_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.push          (push),
		.full          (full),
		.result        (result),
		.empty         (empty),
		.pop           (pop),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.bytes_checked (bytes_checked)
	);

	always #2 clk = ~clk;

	function automatic string entity_name(input int idx);
		case (idx)
			0:       entity_name = "nbsp";
			1:       entity_name = "lt";
			2:       entity_name = "gt";
			3:       entity_name = "amp";
			4:       entity_name = "cent";
			5:       entity_name = "pound";
			6:       entity_name = "yen";
			7:       entity_name = "euro";
			8:       entity_name = "sect";
			9:       entity_name = "copy";
			10:      entity_name = "reg";
			11:      entity_name = "trade";
			12:      entity_name = "apos";
			13:      entity_name = "ndash";
			default: entity_name = "quot";
		endcase
	endfunction

	task automatic add_byte(input logic [7:0] b);
		text_q.insert(text_q.size(), b);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
	endtask

	// Entered and left at a rising edge; the beat is accepted at the edge of return.
	task automatic send_beat(input logic [7:0] b, input logic l);
		int gap;
		gap = calm ? 0 : $urandom_range(3);
		repeat (gap) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= '{in_byte: b, in_last: l};
		@(posedge clk);
		while (full) @(posedge clk);
		beats_sent++;
	endtask

	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++) send_beat(text_q[i], i == text_q.size() - 1);
		text_q.delete();
		texts_sent++;
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	initial begin
		pop = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			repeat (calm ? 0 : $urandom_range(3)) begin
				pop <= 1'b0;
				@(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	initial begin
		#1_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int    tokens;
		int    kind;
		int    idx;
		int    n;
		int    v;
		bit    paused;
		string nm;
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		calm = 1'b0;
		beats_sent = 0;
		texts_sent = 0;
		paused = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// nbsp dropping its follower, hex and zero numbers, a number without digits,
		// byte extremes, then a broken name replayed into a new one that ends the text.
		add_text("&nbsp!&#x41z&#0;&#;");
		add_byte(8'h00);
		add_byte(8'hFF);
		add_text("&a&e");
		send_text();
		wait_drained();

		while (beats_sent < 360) begin
			calm = ($urandom_range(3) == 0);
			tokens = $urandom_range(1, 10);
			repeat (tokens) begin
				kind = $urandom_range(99);
				if (kind < 30) begin
					add_byte(8'($urandom_range(255)));
				end else if (kind < 55) begin
					add_text({"&", entity_name($urandom_range(hesd_pkg::NAME_COUNT - 1))});
					if ($urandom_range(9) < 7) add_byte(";");
					else add_byte(8'($urandom_range(255)));
				end else if (kind < 65) begin
					add_text("&#");
					repeat ($urandom_range(1, 4)) add_byte(8'("0" + $urandom_range(9)));
					add_byte($urandom_range(1) ? ";" : 8'($urandom_range(255)));
				end else if (kind < 77) begin
					add_text("&#x");
					repeat ($urandom_range(1, 3)) begin
						v = $urandom_range(15);
						if (v < 10) add_byte(8'("0" + v));
						else add_byte(8'(($urandom_range(1) ? "a" : "A") + v - 10));
					end
					add_byte($urandom_range(1) ? ";" : 8'($urandom_range(255)));
				end else if (kind < 88) begin
					// A name cut short and broken by an arbitrary byte.
					nm = entity_name($urandom_range(hesd_pkg::NAME_COUNT - 1));
					idx = $urandom_range(1, nm.len() - 1);
					add_text({"&", nm.substr(0, idx - 1)});
					add_byte(8'($urandom_range(255)));
				end else begin
					add_byte("&");
					n = $urandom_range(1, 3);
					repeat (n) begin
						case ($urandom_range(5))
							0:       add_byte("#");
							1:       add_byte("&");
							2:       add_byte("x");
							3:       add_byte(";");
							4:       add_byte("X");
							default: add_byte(8'($urandom_range(255)));
						endcase
					end
				end
			end
			send_text();
			if (!paused && beats_sent >= 200) begin
				paused = 1'b1;
				wait_drained();
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (outstanding != 0) $error("%0d expected output bytes never arrived", outstanding);
		$display("Covered %0d input beats in %0d texts: named, numeric, broken and noisy entities.",
			beats_sent, texts_sent);
		$display("%0d decoded bytes were compared with the prediction.", bytes_checked);
		if (fail_count == 0 && outstanding == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
